>>> rtl/lpkv_pkg.sv
// ----------------------------------------------------------------------------
// lpkv_pkg
// Shared types and constants of the linear-probe key/value table: request and
// status codes, slot marks, register map and the controller/datapath link.
// ----------------------------------------------------------------------------
package lpkv_pkg;

	// stream payload layout
	localparam int REQ_W     = 2;
	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int STAT_W    = 3;
	localparam int LIVE_W    = 9;
	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 48;

	// register map, selected by paddr[2]
	localparam logic REG_MAX_FILL  = 1'b0;
	localparam logic REG_HASH_MULT = 1'b1;
	localparam logic [8:0]  MAX_FILL_RESET  = 9'd192;
	localparam logic [31:0] HASH_MULT_RESET = 32'd2654435761;

	// slot marks
	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_LIVE  = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SET    = 2'd2,
		REQ_GET    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_NOT_FOUND = 3'd1,
		STAT_EXISTS    = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_ABSENT    = 3'd4
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    clear_step;
		logic    accept;
		logic    hash_a;
		logic    hash_b;
		logic    probe_next;
		logic    wr_live;
		logic    wr_tomb;
		logic    wr_value;
		logic    take_value;
		logic    set_status;
		status_t status;
		logic    out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
		logic key_zero;
		logic over_fill;
		logic live_zero;
		req_t req;
		logic mark_empty;
		logic key_match;
		logic probe_last;
		logic out_busy;
	} sts_t;

endpackage

>>> rtl/lpkv_regs.sv
// ----------------------------------------------------------------------------
// lpkv_regs
// APB register block: fill limit and hash multiplier.
// ----------------------------------------------------------------------------
module lpkv_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [8:0]  max_fill,
	output logic [31:0] hash_mult
);

	logic [8:0]  max_fill_q;
	logic [31:0] hash_mult_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fill_q  <= lpkv_pkg::MAX_FILL_RESET;
			hash_mult_q <= lpkv_pkg::HASH_MULT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				lpkv_pkg::REG_MAX_FILL:  max_fill_q  <= pwdata[8:0];
				lpkv_pkg::REG_HASH_MULT: hash_mult_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			lpkv_pkg::REG_MAX_FILL:  prdata = {23'd0, max_fill_q};
			lpkv_pkg::REG_HASH_MULT: prdata = hash_mult_q;
			default:                 prdata = 32'd0;
		endcase
	end

	assign max_fill  = max_fill_q;
	assign hash_mult = hash_mult_q;

endmodule

>>> rtl/lpkv_ctrl.sv
// ----------------------------------------------------------------------------
// lpkv_ctrl
// Request sequencer: clearing pass, hash, slot-by-slot probe, result hand-off.
// ----------------------------------------------------------------------------
module lpkv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lpkv_pkg::sts_t    sts,
	output lpkv_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_HASH_A,
		S_HASH_B,
		S_READ,
		S_PROBE,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_HASH_A;
				end
			end
			S_HASH_A: begin
				cmd.hash_a = 1'b1;
				// settle requests that need no probe
				priority if (sts.key_zero) begin
					cmd.set_status = 1'b1;
					cmd.status     = lpkv_pkg::STAT_ABSENT;
					state_d        = S_DONE;
				end else if (sts.req == lpkv_pkg::REQ_ADD && sts.over_fill) begin
					cmd.set_status = 1'b1;
					cmd.status     = lpkv_pkg::STAT_FULL;
					state_d        = S_DONE;
				end else if (sts.req != lpkv_pkg::REQ_ADD && sts.live_zero) begin
					cmd.set_status = 1'b1;
					cmd.status     = lpkv_pkg::STAT_NOT_FOUND;
					state_d        = S_DONE;
				end else begin
					state_d = S_HASH_B;
				end
			end
			S_HASH_B: begin
				cmd.hash_b = 1'b1;
				state_d    = S_READ;
			end
			S_READ: begin
				state_d = S_PROBE;
			end
			S_PROBE: begin
				cmd.set_status = 1'b1;
				cmd.status     = lpkv_pkg::STAT_OK;
				state_d        = S_DONE;
				priority if (sts.mark_empty) begin
					if (sts.req == lpkv_pkg::REQ_ADD) cmd.wr_live = 1'b1;
					else cmd.status = lpkv_pkg::STAT_NOT_FOUND;
				end else if (sts.key_match) begin
					unique case (sts.req)
						lpkv_pkg::REQ_ADD:    cmd.status     = lpkv_pkg::STAT_EXISTS;
						lpkv_pkg::REQ_REMOVE: cmd.wr_tomb    = 1'b1;
						lpkv_pkg::REQ_SET:    cmd.wr_value   = 1'b1;
						lpkv_pkg::REQ_GET:    cmd.take_value = 1'b1;
						default: ;
					endcase
				end else if (sts.probe_last) begin
					if (sts.req == lpkv_pkg::REQ_ADD) cmd.status = lpkv_pkg::STAT_FULL;
					else cmd.status = lpkv_pkg::STAT_NOT_FOUND;
				end else begin
					// advance to the next slot, keep probing
					cmd.set_status = 1'b0;
					cmd.probe_next = 1'b1;
					state_d        = S_PROBE;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/lpkv_datapath.sv
// ----------------------------------------------------------------------------
// lpkv_datapath
// Slot memory, hash unit, probe pointer, entry counters and output register.
// ----------------------------------------------------------------------------
module lpkv_datapath #(
	parameter int SLOTS      = 256,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lpkv_pkg::cmd_t                      cmd,
	output lpkv_pkg::sts_t                      sts,
	input  logic [lpkv_pkg::IN_DATA_W-1:0]      in_data,
	input  logic [8:0]                          max_fill,
	input  logic [31:0]                         hash_mult,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lpkv_pkg::OUT_DATA_W-1:0]     out_data
);

	localparam int SW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int KW    = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int VW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int EW    = 2 + KW + VW;
	localparam int PW    = 32 + CW;
	localparam int FW    = CW + 10;
	localparam int LIMIT = (SLOTS + 9) / 10;

	// slot entry: {mark, key, value}
	logic [EW-1:0] mem [SLOTS];
	logic [EW-1:0] rd_s1;
	logic [SW-1:0] rd_addr;
	logic          we;
	logic [SW-1:0] wa;
	logic [EW-1:0] wd;

	lpkv_pkg::req_t req_q;
	logic [KW-1:0]  key_q;
	logic [VW-1:0]  val_q;
	logic [31:0]    h_q;
	logic [SW-1:0]  slot_q;
	logic [SW-1:0]  probe_q;
	logic [SW-1:0]  clr_q;
	logic [SW-1:0]  slot_nxt;
	logic [CW-1:0]  live_q;
	logic [CW-1:0]  tomb_q;
	lpkv_pkg::status_t st_q;
	logic [VW-1:0]  rv_q;

	logic           out_valid_q;
	logic [2:0]     o_status_q;
	logic [31:0]    o_value_q;
	logic [8:0]     o_live_q;
	logic           o_rebuild_q;

	logic [31:0]    hprod;
	logic [PW-1:0]  sprod;
	logic [1:0]     rd_mark;
	logic [KW-1:0]  rd_key;
	logic [VW-1:0]  rd_val;
	logic [CW+8:0]  live_ext;

	assign rd_mark = rd_s1[EW-1 -: 2];
	assign rd_key  = rd_s1[VW +: KW];
	assign rd_val  = rd_s1[VW-1:0];

	assign hprod    = 32'(key_q) * hash_mult;
	assign sprod    = PW'(h_q) * PW'(SLOTS);
	assign slot_nxt = (slot_q == SW'(SLOTS - 1)) ? '0 : slot_q + 1'b1;
	assign rd_addr  = cmd.probe_next ? slot_nxt : slot_q;
	assign live_ext = (CW + 9)'(live_q);

	always_comb begin
		we = 1'b1;
		wa = slot_q;
		wd = '0;
		priority if (cmd.clear_step) begin
			wa = clr_q;
		end else if (cmd.wr_live) begin
			wd = {lpkv_pkg::MARK_LIVE, key_q, val_q};
		end else if (cmd.wr_tomb) begin
			wd = {lpkv_pkg::MARK_TOMB, rd_key, rd_val};
		end else if (cmd.wr_value) begin
			wd = {lpkv_pkg::MARK_LIVE, rd_key, val_q};
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1 <= mem[rd_addr];
		if (we) mem[wa] <= wd;
	end

	// request, hash, probe pointer, status and read value
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= lpkv_pkg::req_t'(in_data[1:0]);
			key_q <= in_data[2 +: KW];
			val_q <= in_data[34 +: VW];
			rv_q  <= '0;
		end
		if (cmd.hash_a) h_q <= hprod;
		if (cmd.hash_b) begin
			slot_q  <= sprod[32 +: SW];
			probe_q <= '0;
		end else if (cmd.probe_next) begin
			slot_q  <= slot_nxt;
			probe_q <= probe_q + 1'b1;
		end
		if (cmd.set_status) st_q <= cmd.status;
		if (cmd.take_value) rv_q <= rd_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			live_q <= '0;
			tomb_q <= '0;
		end else begin
			if (cmd.clear_step) clr_q <= clr_q + 1'b1;
			if (cmd.wr_live) live_q <= live_q + 1'b1;
			if (cmd.wr_tomb) begin
				live_q <= live_q - 1'b1;
				tomb_q <= tomb_q + 1'b1;
			end
		end
	end

	// output register; hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_status_q  <= st_q;
			o_value_q   <= 32'(rv_q);
			o_live_q    <= live_ext[8:0];
			o_rebuild_q <= (tomb_q > CW'(LIMIT)) && (live_q < tomb_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {3'd0, o_rebuild_q, o_live_q, o_value_q, o_status_q};

	always_comb begin
		sts            = '0;
		sts.clear_last = (clr_q == SW'(SLOTS - 1));
		sts.key_zero   = (key_q == '0);
		sts.over_fill  = (FW'(live_q) + 1'b1) > FW'(max_fill);
		sts.live_zero  = (live_q == '0);
		sts.req        = req_q;
		sts.mark_empty = (rd_mark == lpkv_pkg::MARK_EMPTY);
		sts.key_match  = (rd_mark == lpkv_pkg::MARK_LIVE) && (rd_key == key_q);
		sts.probe_last = (probe_q == SW'(SLOTS - 1));
		sts.out_busy   = out_valid_q && !out_ready;
	end

endmodule

>>> rtl/linear_probe_key_value_table.sv
// ----------------------------------------------------------------------------
// linear_probe_key_value_table
// Open-addressing key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel, one per transfer; each yields exactly
//   one result transfer on the m_ channel, in order. Fill limit and hash
//   multiplier are to be written over APB only while the table is idle;
//   the block itself does not enforce this. A request goes from acceptance
//   through the hash multiply (S_HASH_A, S_HASH_B), one memory read (S_READ)
//   and a probe of 1 to SLOTS slots, one slot per cycle through the
//   registered read port of the slot memory, to the loading of the result
//   (S_DONE). A zero key, an add over the fill limit or a remove, set or get
//   on an empty table skips the probe and goes from S_HASH_A straight to
//   S_DONE. A new request is taken only once the previous result is loaded.
//   After reset the slot marks are cleared by a pass over every slot; s_tready
//   stays low meanwhile, APB writes are taken as usual.
//   Results sit in an output register: when m_tready is low the result is
//   held, the next request is still accepted and probed, and it waits only
//   for the register to be freed before its own result is loaded.
// ----------------------------------------------------------------------------
module linear_probe_key_value_table #(
	parameter int SLOTS      = 256,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // req_type[1:0], key[33:2], value[65:34], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // status[2:0], read_value[34:3], live_entries[43:35],
	                               // rebuild_due[44], zero pad
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	lpkv_pkg::cmd_t cmd;
	lpkv_pkg::sts_t sts;
	logic [8:0]     max_fill;
	logic [31:0]    hash_mult;

	lpkv_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.max_fill  (max_fill),
		.hash_mult (hash_mult)
	);

	lpkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpkv_datapath #(
		.SLOTS      (SLOTS),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.max_fill  (max_fill),
		.hash_mult (hash_mult),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
